### design/rbcc_pkg.sv
// shared types and constants for the refcounted block cache controller
package rbcc_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int BLOCK_BITS = 32;
   localparam int REF_W      = 8;
   localparam int CNT_W      = 5;

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_DIRTY   = 2'd2,
      OP_FLUSH   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FREE  = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC,
      S_SEND
   } state_type;

   typedef enum logic [2:0] {
      FC_NONE,
      FC_ALLOC,
      FC_INC,
      FC_DEC,
      FC_SET_DIRTY,
      FC_CLR_DIRTY
   } frame_op_type;

   typedef enum logic [2:0] {
      LC_NONE,
      LC_REMOVE,
      LC_APPEND,
      LC_PUSH,
      LC_POP
   } list_op_type;

   typedef struct packed {
      frame_op_type          op;
      logic [BLOCK_BITS-1:0] tag;
   } frame_cmd_type;

   typedef struct packed {
      list_op_type      op;
      logic [IDX_W-1:0] key;
   } list_cmd_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] block_number;
      logic [3:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [3:0]  frame;
      logic        fetch;
      logic        writeback;
      logic [31:0] writeback_block;
      logic        last;
   } rsp_type;

endpackage

### design/rbcc_frame_cell.sv
// one cache frame: tag, valid, reference count and dirty flag
module rbcc_frame_cell import rbcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  frame_cmd_type         cmd,
   input  logic                  sel,
   input  logic [BLOCK_BITS-1:0] key,
   input  logic                  found_in,
   output logic                  found_out,
   output logic                  first,
   output logic [BLOCK_BITS-1:0] tag,
   output logic                  vld,
   output logic [REF_W-1:0]      refs,
   output logic                  dirty
);

   logic [BLOCK_BITS-1:0] tag_ff, tag_in;
   logic                  vld_ff, vld_in;
   logic [REF_W-1:0]      ref_ff, ref_in;
   logic                  dirty_ff, dirty_in;
   logic                  match;

   assign match     = vld_ff && (tag_ff == key);
   // first hit wins, later cells see it through the chain
   assign first     = match && !found_in;
   assign found_out = found_in || match;
   assign tag       = tag_ff;
   assign vld       = vld_ff;
   assign refs      = ref_ff;
   assign dirty     = dirty_ff;

   always_comb begin
      tag_in   = tag_ff;
      vld_in   = vld_ff;
      ref_in   = ref_ff;
      dirty_in = dirty_ff;
      if (sel) begin
         case (cmd.op)
            FC_ALLOC: begin
               tag_in   = cmd.tag;
               vld_in   = 1'b1;
               ref_in   = REF_W'(1);
               dirty_in = 1'b0;
            end
            FC_INC: begin
               if (ref_ff != '1) ref_in = ref_ff + REF_W'(1);
            end
            FC_DEC:       ref_in   = ref_ff - REF_W'(1);
            FC_SET_DIRTY: dirty_in = 1'b1;
            FC_CLR_DIRTY: dirty_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         vld_ff   <= 1'b0;
         ref_ff   <= '0;
         dirty_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         ref_ff   <= ref_in;
         dirty_ff <= dirty_in;
      end
   end

endmodule

### design/rbcc_list_cell.sv
// one slot of an ordered frame list; slots shift toward their neighbors
module rbcc_list_cell import rbcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  list_cmd_type     cmd,
   input  logic [IDX_W-1:0] prev_val,
   input  logic             prev_vld,
   input  logic [IDX_W-1:0] next_val,
   input  logic             next_vld,
   input  logic             kill_in,
   output logic             kill_out,
   output logic [IDX_W-1:0] val,
   output logic             vld
);

   logic [IDX_W-1:0] val_ff, val_in;
   logic             vld_ff, vld_in;

   // removal point and everything after it closes up
   assign kill_out = kill_in || (vld_ff && (val_ff == cmd.key));
   assign val      = val_ff;
   assign vld      = vld_ff;

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      case (cmd.op)
         LC_REMOVE: begin
            if (kill_out) begin
               val_in = next_val;
               vld_in = next_vld;
            end
         end
         LC_APPEND: begin
            if (!vld_ff && prev_vld) begin
               val_in = cmd.key;
               vld_in = 1'b1;
            end
         end
         LC_PUSH: begin
            val_in = prev_val;
            vld_in = prev_vld;
         end
         LC_POP: begin
            val_in = next_val;
            vld_in = next_vld;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
   end

endmodule

### design/refcounted_block_cache_controller_unit.sv
// top level of the refcounted block cache controller
// Block cache tag and replacement controller built from a row of frame cells
// (tag, valid, count, dirty) and two chains of list cells holding the free
// queue (oldest at the head) and the dirty list (newest at the head). One
// request is handled at a time: accept, tag search across the frame cells,
// update of the cells, then the result transaction is held until taken. A
// flush produces one writeback transaction per dirty frame, popping the dirty
// list head each time, or a single result without writeback if the list is
// empty. req_stall is high from acceptance until the last result has been
// taken. The csr port is always ready and sets the capacity in frames.
module refcounted_block_cache_controller_unit import rbcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata
);

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CNT_W-1:0]      max_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_load;

   frame_cmd_type         fcmd;
   logic [IDX_W-1:0]      fidx;
   list_cmd_type          fq_cmd, dl_cmd;

   logic [NUM_FRAMES-1:0]  sel;
   logic [NUM_FRAMES:0]    found;
   logic [NUM_FRAMES-1:0]  first;
   logic [BLOCK_BITS-1:0]  c_tag   [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]  c_vld;
   logic [REF_W-1:0]       c_ref   [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]  c_dirty;

   logic [IDX_W-1:0]      fq_val [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] fq_vld;
   logic [NUM_FRAMES:0]   fq_kill;
   logic [IDX_W-1:0]      dl_val [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] dl_vld;
   logic [NUM_FRAMES:0]   dl_kill;

   logic [IDX_W-1:0]      hit_idx;
   logic [CNT_W-1:0]      cap;
   logic [IDX_W-1:0]      fi, fq_head, dl_head;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign rsp_data  = rsp_ff;

   assign found[0]   = 1'b0;
   assign fq_kill[0] = 1'b0;
   assign dl_kill[0] = 1'b0;

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cells
      assign sel[i] = (fidx == IDX_W'(i));

      rbcc_frame_cell u_frame (
         .clock     (clock),
         .reset     (reset),
         .cmd       (fcmd),
         .sel       (sel[i]),
         .key       (req_ff.block_number),
         .found_in  (found[i]),
         .found_out (found[i+1]),
         .first     (first[i]),
         .tag       (c_tag[i]),
         .vld       (c_vld[i]),
         .refs      (c_ref[i]),
         .dirty     (c_dirty[i])
      );

      rbcc_list_cell u_free (
         .clock    (clock),
         .reset    (reset),
         .cmd      (fq_cmd),
         .prev_val ((i == 0) ? fq_cmd.key : fq_val[(i == 0) ? 0 : i-1]),
         .prev_vld ((i == 0) ? 1'b1 : fq_vld[(i == 0) ? 0 : i-1]),
         .next_val ((i == NUM_FRAMES-1) ? '0 : fq_val[(i == NUM_FRAMES-1) ? i : i+1]),
         .next_vld ((i == NUM_FRAMES-1) ? 1'b0 : fq_vld[(i == NUM_FRAMES-1) ? i : i+1]),
         .kill_in  (fq_kill[i]),
         .kill_out (fq_kill[i+1]),
         .val      (fq_val[i]),
         .vld      (fq_vld[i])
      );

      rbcc_list_cell u_dirty (
         .clock    (clock),
         .reset    (reset),
         .cmd      (dl_cmd),
         .prev_val ((i == 0) ? dl_cmd.key : dl_val[(i == 0) ? 0 : i-1]),
         .prev_vld ((i == 0) ? 1'b1 : dl_vld[(i == 0) ? 0 : i-1]),
         .next_val ((i == NUM_FRAMES-1) ? '0 : dl_val[(i == NUM_FRAMES-1) ? i : i+1]),
         .next_vld ((i == NUM_FRAMES-1) ? 1'b0 : dl_vld[(i == NUM_FRAMES-1) ? i : i+1]),
         .kill_in  (dl_kill[i]),
         .kill_out (dl_kill[i+1]),
         .val      (dl_val[i]),
         .vld      (dl_vld[i])
      );
   end

   // one-hot first match to an index
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < NUM_FRAMES; i++)
         if (first[i]) hit_idx = hit_idx | IDX_W'(i);
   end

   assign cap     = (max_ff < CNT_W'(NUM_FRAMES)) ? max_ff : CNT_W'(NUM_FRAMES);
   assign fi      = req_ff.frame_index[IDX_W-1:0];
   assign fq_head = fq_val[0];
   assign dl_head = dl_val[0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SEARCH;
         S_SEARCH: state_in = S_EXEC;
         S_EXEC:   state_in = S_SEND;
         S_SEND: begin
            if (!rsp_stall) begin
               if (req_ff.opcode == OP_FLUSH && !rsp_ff.last) state_in = S_EXEC;
               else                                          state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // cell commands and result
   always_comb begin
      fcmd     = '{op: FC_NONE, tag: req_ff.block_number};
      fidx     = fi;
      fq_cmd   = '{op: LC_NONE, key: '0};
      dl_cmd   = '{op: LC_NONE, key: '0};
      used_in  = used_ff;
      rsp_in   = '0;
      rsp_load = 1'b0;
      rsp_in.last = 1'b1;
      if (state_ff == S_EXEC) begin
         rsp_load = 1'b1;
         unique case (opcode_type'(req_ff.opcode))
            OP_GET: begin
               if (hit_ff) begin
                  fidx     = hit_idx_ff;
                  fcmd.op  = FC_INC;
                  if (c_ref[hit_idx_ff] == '0) fq_cmd = '{op: LC_REMOVE, key: hit_idx_ff};
                  rsp_in.hit   = 1'b1;
                  rsp_in.frame = 4'(hit_idx_ff);
               end else if (used_ff < cap) begin
                  fidx    = used_ff[IDX_W-1:0];
                  fcmd.op = FC_ALLOC;
                  used_in = used_ff + CNT_W'(1);
                  rsp_in.frame = 4'(used_ff[IDX_W-1:0]);
                  rsp_in.fetch = 1'b1;
               end else if (!fq_vld[0]) begin
                  rsp_in.status = ST_NO_FREE;
               end else begin
                  fidx    = fq_head;
                  fcmd.op = FC_ALLOC;
                  fq_cmd  = '{op: LC_REMOVE, key: fq_head};
                  if (c_dirty[fq_head]) begin
                     dl_cmd = '{op: LC_REMOVE, key: fq_head};
                     rsp_in.writeback       = 1'b1;
                     rsp_in.writeback_block = c_tag[fq_head];
                  end
                  rsp_in.frame = 4'(fq_head);
                  rsp_in.fetch = 1'b1;
               end
            end
            OP_RELEASE: begin
               rsp_in.frame = req_ff.frame_index;
               if (!c_vld[fi] || c_ref[fi] == '0) begin
                  rsp_in.status = ST_BAD;
               end else begin
                  fcmd.op = FC_DEC;
                  if (c_ref[fi] == REF_W'(1)) fq_cmd = '{op: LC_APPEND, key: fi};
               end
            end
            OP_DIRTY: begin
               rsp_in.frame = req_ff.frame_index;
               if (!c_vld[fi]) begin
                  rsp_in.status = ST_BAD;
               end else if (!c_dirty[fi]) begin
                  fcmd.op = FC_SET_DIRTY;
                  dl_cmd  = '{op: LC_PUSH, key: fi};
               end
            end
            OP_FLUSH: begin
               if (dl_vld[0]) begin
                  fidx    = dl_head;
                  fcmd.op = FC_CLR_DIRTY;
                  dl_cmd  = '{op: LC_POP, key: dl_head};
                  rsp_in.frame           = 4'(dl_head);
                  rsp_in.writeback       = 1'b1;
                  rsp_in.writeback_block = c_tag[dl_head];
                  rsp_in.last            = !dl_vld[1];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_SEARCH) begin
         hit_ff     <= found[NUM_FRAMES];
         hit_idx_ff <= hit_idx;
      end
      if (rsp_load) rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         max_ff   <= CNT_W'(NUM_FRAMES);
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_valid) max_ff <= csr_wdata;
      end
   end

endmodule

### bench/refcounted_block_cache_controller_unit_tb.sv
// testbench for the refcounted block cache controller: directed table and cases, then random traffic
module refcounted_block_cache_controller_unit_tb import rbcc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_wdata = '0;

   refcounted_block_cache_controller_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // cache shadow state
   logic [31:0] tag_q [NUM_FRAMES];
   logic        valid_q [NUM_FRAMES];
   logic [7:0]  count_q [NUM_FRAMES];
   logic        dirty_q [NUM_FRAMES];
   logic [3:0]  free_list [$];
   logic [3:0]  dirty_list [$];
   int          frames_used;
   logic [4:0]  capacity_reg;

   rsp_type expected_rsp [$];
   int errors = 0;
   int cycles = 0;
   int n_rsp = 0;
   int n_hits = 0;
   int n_wb = 0;
   int n_nofree = 0;
   int n_bad = 0;
   bit hold_off = 0;
   bit gate_off = 0;

   function automatic rsp_type make_rsp(status_type st, logic h, logic [3:0] fr, logic fe,
                                        logic wb, logic [31:0] wbb, logic lst);
      rsp_type r;
      r.status = st;
      r.hit = h;
      r.frame = fr;
      r.fetch = fe;
      r.writeback = wb;
      r.writeback_block = wbb;
      r.last = lst;
      return r;
   endfunction

   function automatic void drop_free(logic [3:0] f);
      foreach (free_list[i])
         if (free_list[i] == f) begin
            free_list.delete(i);
            return;
         end
   endfunction

   // computes the responses of one request and updates the shadow cache
   function automatic void cache_predict(req_type rq);
      int cap;
      int f;
      int n;
      logic wb;
      logic [31:0] wbb;
      cap = capacity_reg < NUM_FRAMES ? capacity_reg : NUM_FRAMES;
      case (opcode_type'(rq.opcode))
         OP_GET: begin
            for (int i = 0; i < NUM_FRAMES; i++)
               if (valid_q[i] && tag_q[i] == rq.block_number) begin
                  if (count_q[i] == 0) drop_free(i[3:0]);
                  if (count_q[i] != 8'hff) count_q[i]++;
                  expected_rsp.push_back(make_rsp(ST_OK, 1, i[3:0], 0, 0, 0, 1));
                  return;
               end
            wb = 0;
            wbb = 0;
            if (frames_used < cap) begin
               f = frames_used;
               frames_used++;
            end else if (free_list.size() == 0) begin
               expected_rsp.push_back(make_rsp(ST_NO_FREE, 0, 0, 0, 0, 0, 1));
               return;
            end else begin
               f = free_list.pop_front();
               if (dirty_q[f]) begin
                  wb = 1;
                  wbb = tag_q[f];
                  dirty_q[f] = 0;
                  foreach (dirty_list[i])
                     if (dirty_list[i] == f) begin
                        dirty_list.delete(i);
                        break;
                     end
               end
            end
            valid_q[f] = 1;
            tag_q[f] = rq.block_number;
            count_q[f] = 1;
            expected_rsp.push_back(make_rsp(ST_OK, 0, f[3:0], 1, wb, wbb, 1));
         end
         OP_RELEASE: begin
            if (!valid_q[rq.frame_index] || count_q[rq.frame_index] == 0) begin
               expected_rsp.push_back(make_rsp(ST_BAD, 0, rq.frame_index, 0, 0, 0, 1));
               return;
            end
            count_q[rq.frame_index]--;
            if (count_q[rq.frame_index] == 0) free_list.push_back(rq.frame_index);
            expected_rsp.push_back(make_rsp(ST_OK, 0, rq.frame_index, 0, 0, 0, 1));
         end
         OP_DIRTY: begin
            if (!valid_q[rq.frame_index]) begin
               expected_rsp.push_back(make_rsp(ST_BAD, 0, rq.frame_index, 0, 0, 0, 1));
               return;
            end
            if (!dirty_q[rq.frame_index]) begin
               dirty_q[rq.frame_index] = 1;
               dirty_list.push_front(rq.frame_index);
            end
            expected_rsp.push_back(make_rsp(ST_OK, 0, rq.frame_index, 0, 0, 0, 1));
         end
         default: begin
            n = dirty_list.size() < 16 ? dirty_list.size() : 16;
            if (n == 0) expected_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 0, 0, 1));
            for (int i = 0; i < n; i++) begin
               f = dirty_list.pop_front();
               dirty_q[f] = 0;
               expected_rsp.push_back(make_rsp(ST_OK, 0, f[3:0], 0, 1, tag_q[f], i == n - 1));
            end
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response transaction %p", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            n_rsp++;
            if (rsp_data.hit) n_hits++;
            if (rsp_data.writeback) n_wb++;
            if (rsp_data.status == ST_NO_FREE) n_nofree++;
            if (rsp_data.status == ST_BAD) n_bad++;
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.hit !== e.hit) begin
               $error("hit expected %0d actual %0d", e.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.frame !== e.frame) begin
               $error("frame expected %0d actual %0d", e.frame, rsp_data.frame);
               errors++;
            end
            if (rsp_data.fetch !== e.fetch) begin
               $error("fetch expected %0d actual %0d", e.fetch, rsp_data.fetch);
               errors++;
            end
            if (rsp_data.writeback !== e.writeback) begin
               $error("writeback expected %0d actual %0d", e.writeback, rsp_data.writeback);
               errors++;
            end
            if (rsp_data.writeback_block !== e.writeback_block) begin
               $error("writeback_block expected %h actual %h", e.writeback_block,
                      rsp_data.writeback_block);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         repeat (60) @(posedge clock);
         hold_off = 0;
         rsp_stall <= 1'b0;
      end else if (gate_off) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (($urandom_range(0, 99) < 30) && (cycles % 200 < 140));
      end
   end

   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("refcounted_block_cache_controller_unit test failed");
         $finish;
      end

   // valid drops after each accepted transaction while the block is busy anyway
   task automatic send_request(req_type rq);
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      cache_predict(rq);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_write(logic [4:0] value);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_request(int span);
      req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      rq.block_number = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, span);
      rq.frame_index = $urandom_range(0, 15);
      if (pick < 40) rq.opcode = OP_GET;
      else if (pick < 75) rq.opcode = OP_RELEASE;
      else if (pick < 93) rq.opcode = OP_DIRTY;
      else rq.opcode = OP_FLUSH;
      return rq;
   endfunction

   // directed rows: op, block, frame, whether expected is typed in, expected response
   typedef struct {
      opcode_type  op;
      logic [31:0] blk;
      logic [3:0]  fi;
      bit          typed;
      rsp_type     rsp;
   } stim_row_type;

   stim_row_type rows [$];

   initial begin
      req_type rq;
      int burst;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         tag_q[i] = 0;
         valid_q[i] = 0;
         count_q[i] = 0;
         dirty_q[i] = 0;
      end
      frames_used = 0;
      capacity_reg = 5'd16;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{OP_FLUSH, 0, 0, 1, make_rsp(ST_OK, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{OP_RELEASE, 0, 15, 1, make_rsp(ST_BAD, 0, 15, 0, 0, 0, 1)});
      rows.push_back('{OP_DIRTY, 0, 3, 1, make_rsp(ST_BAD, 0, 3, 0, 0, 0, 1)});
      rows.push_back('{OP_GET, 32'h0, 0, 1, make_rsp(ST_OK, 0, 0, 1, 0, 0, 1)});
      rows.push_back('{OP_GET, 32'hffff_ffff, 0, 1, make_rsp(ST_OK, 0, 1, 1, 0, 0, 1)});
      rows.push_back('{OP_GET, 32'hffff_ffff, 0, 1, make_rsp(ST_OK, 1, 1, 0, 0, 0, 1)});
      rows.push_back('{OP_DIRTY, 0, 1, 0, '0});
      rows.push_back('{OP_DIRTY, 0, 1, 0, '0});
      rows.push_back('{OP_DIRTY, 0, 0, 0, '0});
      rows.push_back('{OP_RELEASE, 0, 0, 0, '0});
      rows.push_back('{OP_RELEASE, 0, 0, 1, make_rsp(ST_BAD, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{OP_FLUSH, 0, 0, 0, '0});
      rows.push_back('{OP_DIRTY, 0, 0, 0, '0});
      foreach (rows[i]) begin
         rq.opcode = rows[i].op;
         rq.block_number = rows[i].blk;
         rq.frame_index = rows[i].fi;
         if (rows[i].typed) begin
            send_request(rq);
            if (expected_rsp[$] !== rows[i].rsp) begin
               $error("table row %0d expected %p predicted %p", i, rows[i].rsp, expected_rsp[$]);
               errors++;
            end
         end else
            send_request(rq);
      end

      // capacity of 1: evict frame 0 (dirty, released in the table), then no free frame
      drain_and_write(5'd1);
      rq = '{OP_GET, 32'h1234_5678, 4'd0};
      send_request(rq);
      rq = '{OP_RELEASE, 0, 4'd1};
      send_request(rq);
      rq = '{OP_GET, 32'h1234_5678, 4'd0};
      send_request(rq);
      rq = '{OP_GET, 32'h0, 4'd0};
      send_request(rq);

      // count saturation on frame 2
      drain_and_write(5'd31);
      for (int i = 0; i < 258; i++) send_request('{OP_GET, 32'hcafe_0000, 4'd0});
      drain_and_write(5'd0);
      send_request('{OP_GET, 32'hdead_beef, 4'd0});

      // random phases across capacities; mostly small block range to get hits
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: drain_and_write(5'd16);
            1: drain_and_write(5'd4);
            2: drain_and_write(5'd31);
            3: drain_and_write(5'd2);
            4: drain_and_write(5'd0);
            default: drain_and_write(5'd9);
         endcase
         for (int k = 0; k < 36; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k < 36; b++, k++) begin
               rq = random_request(ph == 2 ? 40 : 24);
               // the one forced flush, after a dirty request to every frame
               if (ph == 2 && k == 20) begin
                  for (int d = 0; d < NUM_FRAMES; d++) send_request('{OP_DIRTY, 0, d[3:0]});
                  rq.opcode = OP_FLUSH;
               end
               if (ph == 1 && k == 20) hold_off = 1;
               send_request(rq);
            end
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 8)) @(posedge clock);
            if (ph == 3 && k > 20 && k < 30) begin
               gate_off = 1;
               while (expected_rsp.size() != 0) @(posedge clock);
               gate_off = 0;
            end
         end
      end

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d responses: %0d hits, %0d writebacks, %0d no-free, %0d bad frame",
               n_rsp, n_hits, n_wb, n_nofree, n_bad);
      $display("capacities 0, 1, 2, 4, 9, 16 and 31 exercised, count saturation included");
      if (errors == 0)
         $display("refcounted_block_cache_controller_unit test passed");
      else
         $display("refcounted_block_cache_controller_unit test failed");
      $finish;
   end
endmodule
